// ----- hdl/pip_pkg.sv -----
// package: shared constants, payload types and edge test interface types for the polygon test
`default_nettype none
package pip_pkg;

  // polygon capacity and coordinate width
  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 24;
  localparam int MIN_VERTICES = 3;

  // fixed field widths
  localparam int VIDX_BITS = 6;
  localparam int CNT_BITS  = 7;

  // derived widths
  localparam int ADDR_BITS = $clog2(MAX_VERTICES);
  localparam int NUM_BITS  = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int VERT_BITS = 2 * COORD_BITS;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // input word
  typedef struct packed {
    logic                          operation;
    logic [VIDX_BITS-1:0]          vertex_index;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;
  } pip_in_t;

  // result word
  typedef struct packed {
    logic inside_res;
    logic too_few_vertices;
  } pip_out_t;

  // one edge to test against the query point
  typedef struct packed {
    logic                          valid;
    logic signed [COORD_BITS-1:0]  px;
    logic signed [COORD_BITS-1:0]  py;
    logic signed [COORD_BITS-1:0]  x1;
    logic signed [COORD_BITS-1:0]  y1;
    logic signed [COORD_BITS-1:0]  x2;
    logic signed [COORD_BITS-1:0]  y2;
  } edge_req_t;

  // edge test status back to the sequencer
  typedef struct packed {
    logic busy;
    logic valid;
    logic flip;
  } edge_res_t;

endpackage
`default_nettype wire

// ----- hdl/pip_ram.sv -----
// generic single write port ram with registered read
`default_nettype none
module pip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/pip_edge_unit.sv -----
// pipelined crossing test of one polygon edge per cycle
`default_nettype none
module pip_edge_unit
  import pip_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire edge_req_t req,
  output edge_res_t      res
);

  logic signed [COORD_BITS-1:0] px, py, x1, y1, x2, y2;
  logic signed [DIFF_BITS-1:0]  px_e, py_e, x1_e, y1_e, x2_e, y2_e;
  logic signed [COORD_BITS-1:0] ymin, ymax, xmax;
  logic                         gate, vert, dy_pos;

  // stage 1 registers
  logic                         s1_v_r, s1_gate_r, s1_vert_r;
  logic signed [DIFF_BITS-1:0]  s1_dist_r, s1_d_r, s1_t_r, s1_run_r;
  // stage 2 registers
  logic                         s2_v_r, s2_gate_r, s2_vert_r;
  logic signed [PROD_BITS-1:0]  s2_lhs_r, s2_rhs_r;

  assign px = req.px;
  assign py = req.py;
  assign x1 = req.x1;
  assign y1 = req.y1;
  assign x2 = req.x2;
  assign y2 = req.y2;

  assign px_e = DIFF_BITS'(px);
  assign py_e = DIFF_BITS'(py);
  assign x1_e = DIFF_BITS'(x1);
  assign y1_e = DIFF_BITS'(y1);
  assign x2_e = DIFF_BITS'(x2);
  assign y2_e = DIFF_BITS'(y2);

  // edge extent and the half-open y window
  assign ymin   = (y1 < y2) ? y1 : y2;
  assign ymax   = (y1 < y2) ? y2 : y1;
  assign xmax   = (x1 < x2) ? x2 : x1;
  assign gate   = (py > ymin) && (py <= ymax) && (px <= xmax) && (y1 != y2);
  assign vert   = (x1 == x2);
  assign dy_pos = (y2 > y1);

  // stage 1: differences, with the y span made positive
  always_ff @(posedge clk) begin
    s1_gate_r <= gate;
    s1_vert_r <= vert;
    s1_dist_r <= px_e - x1_e;
    s1_run_r  <= x2_e - x1_e;
    s1_d_r    <= dy_pos ? (y2_e - y1_e) : (y1_e - y2_e);
    s1_t_r    <= dy_pos ? (py_e - y1_e) : (y1_e - py_e);
  end

  // stage 2: the two cross products
  always_ff @(posedge clk) begin
    s2_gate_r <= s1_gate_r;
    s2_vert_r <= s1_vert_r;
    s2_lhs_r  <= s1_dist_r * s1_d_r;
    s2_rhs_r  <= s1_t_r * s1_run_r;
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= req.valid;
      s2_v_r <= s1_v_r;
    end
  end

  // final compare: point at or left of the crossing
  assign res.valid = s2_v_r;
  assign res.busy  = s1_v_r | s2_v_r;
  assign res.flip  = s2_gate_r && (s2_vert_r || (s2_lhs_r <= s2_rhs_r));

endmodule
`default_nettype wire

// ----- hdl/point_in_polygon_test_unit.sv -----
// top level: vertex store, query sequencer and parity accumulation
// query with n vertices in use (n >= 3): reads the last vertex, then vertices 0 .. n-1,
//   drains the edge pipeline and registers the result; the next word is taken once it is valid
// write word: stored, no result; under three vertices: result registered with too_few_vertices set
// while running, a query makes one vertex ram read and one edge test per cycle
// reset clears control and vertex_count; the vertex store is undefined until written
`default_nettype none
module point_in_polygon_test_unit
  import pip_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pip_in_t             in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output pip_out_t                 out_data,
  input  wire logic                cfg_we,
  input  wire logic [CNT_BITS-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CNT_BITS-1:0]          vcount_r;
  logic [NUM_BITS-1:0]          n_r, n_nxt, n_sat;
  logic [NUM_BITS-1:0]          cnt_r, cnt_nxt;
  logic signed [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic                         few_r, few_nxt;
  logic                         parity_r, parity_nxt;
  logic                         rd_v_r, rd_v_nxt;
  logic                         first_r, first_nxt;
  logic [VERT_BITS-1:0]         prev_r, prev_nxt;
  logic                         out_valid_r, out_valid_nxt;
  pip_out_t                     out_data_r, out_data_nxt;

  logic                         accept, wr_en;
  logic [ADDR_BITS-1:0]         rd_addr;
  logic [VERT_BITS-1:0]         rd_data;
  edge_req_t                    ereq;
  edge_res_t                    eres;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // vertex count register; its value is saturated to capacity when a query starts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  assign n_sat = (int'(vcount_r) > MAX_VERTICES) ? NUM_BITS'(MAX_VERTICES)
                                                  : NUM_BITS'(vcount_r);

  // vertex store, x and y side by side
  assign wr_en   = accept && (in_data.operation == OP_WRITE)
                   && (int'(in_data.vertex_index) < MAX_VERTICES);
  assign rd_addr = (cnt_r == '0) ? ADDR_BITS'(n_r - NUM_BITS'(1))
                                 : ADDR_BITS'(cnt_r - NUM_BITS'(1));

  pip_ram #(
    .WIDTH (VERT_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_vram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ADDR_BITS'(in_data.vertex_index)),
    .wdata ({in_data.coord_x, in_data.coord_y}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // edge from the current vertex to the previous one
  assign ereq.valid = rd_v_r && !first_r;
  assign ereq.px    = px_r;
  assign ereq.py    = py_r;
  assign ereq.x1    = rd_data[VERT_BITS-1:COORD_BITS];
  assign ereq.y1    = rd_data[COORD_BITS-1:0];
  assign ereq.x2    = prev_r[VERT_BITS-1:COORD_BITS];
  assign ereq.y2    = prev_r[COORD_BITS-1:0];

  pip_edge_unit u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ereq),
    .res   (eres)
  );

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    few_nxt       = few_r;
    parity_nxt    = parity_r;
    rd_v_nxt      = 1'b0;
    first_nxt     = 1'b0;
    prev_nxt      = rd_v_r ? rd_data : prev_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (eres.valid && eres.flip) begin
      parity_nxt = !parity_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_data.operation == OP_QUERY)) begin
          n_nxt      = n_sat;
          cnt_nxt    = '0;
          px_nxt     = in_data.coord_x;
          py_nxt     = in_data.coord_y;
          parity_nxt = 1'b0;
          few_nxt    = (int'(n_sat) < MIN_VERTICES);
          state_nxt  = (int'(n_sat) < MIN_VERTICES) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        // one read per cycle: last vertex first, then 0 .. n-1
        rd_v_nxt  = 1'b1;
        first_nxt = (cnt_r == '0);
        cnt_nxt   = cnt_r + NUM_BITS'(1);
        if (cnt_r == n_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_v_r && !eres.busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.inside_res       = parity_r && !few_r;
          out_data_nxt.too_few_vertices = few_r;
          state_nxt                   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= rd_v_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    cnt_r      <= cnt_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    few_r      <= few_nxt;
    parity_r   <= parity_nxt;
    prev_r     <= prev_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ----- hdl/pip_checker.sv -----
// port checker for the polygon test unit and its bind
`default_nettype none
module pip_port_checker
  import pip_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire pip_in_t             in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire pip_out_t            out_data,
  input wire logic                cfg_we,
  input wire logic [CNT_BITS-1:0] cfg_wdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or dropped while stalled");

  // a degenerate polygon never reports inside
  a_few_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.too_few_vertices && out_data.inside_res))
    else $error("inside reported with too few vertices");

  // a query keeps the unit busy for at least the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.operation == OP_QUERY) |=> !in_ready)
    else $error("query accepted but unit still ready");

  // vertex count written only while idle, with known data
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> in_ready && !$isunknown(cfg_wdata))
    else $error("vertex count written while busy or with unknown data");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind point_in_polygon_test_unit pip_port_checker u_pip_checker (.*);
`default_nettype wire
